>>> hdl/rocc_pkg.sv
package rocc_pkg;

    // Field widths fixed by the interface
    localparam int VALUE_BITS_DEF = 32;
    localparam int TIME_W         = 32;
    localparam int LIMIT_W        = 31;
    localparam int RATE_W         = 48;
    localparam int EN_W           = 3;
    localparam int STATUS_W       = 3;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 32;

    // 3600 = 15 * 15 * 16; one step of x15 is (x << 4) - x
    localparam int MUL_DIGIT = 4;
    // Bits added by the scale by 3600
    localparam int SCALE_W   = 12;

    // Bit positions in the enables field
    localparam int EN_QC    = 0;
    localparam int EN_ALARM = 1;
    localparam int EN_ALERT = 2;

    // Saturation magnitudes of a 48-bit rate
    localparam logic [RATE_W-1:0] RATE_MAG_POS = {1'b0, {(RATE_W-1){1'b1}}};
    localparam logic [RATE_W-1:0] RATE_MAG_NEG = {1'b1, {(RATE_W-1){1'b0}}};

    typedef enum logic [STATUS_W-1:0] {
        ST_NONE     = 3'd0,
        ST_OKAY     = 3'd1,
        ST_QC       = 3'd2,
        ST_ALARM    = 3'd3,
        ST_ALERT    = 3'd4,
        ST_CONFLICT = 3'd5
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_QC_LIMIT    = 3'd0,
        CFG_ALARM_LIMIT = 3'd1,
        CFG_ALERT_LIMIT = 3'd2,
        CFG_ENABLES     = 3'd3,
        CFG_ACCUM       = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [LIMIT_W-1:0] qc_limit;
        logic [LIMIT_W-1:0] alarm_limit;
        logic [LIMIT_W-1:0] alert_limit;
        logic [EN_W-1:0]    enables;
        logic               accum;
    } t_cfg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_ABS,
        S_MUL1,
        S_MUL2,
        S_DSTART,
        S_DIV,
        S_SAT,
        S_CLASS,
        S_DONE
    } t_state;

endpackage

>>> hdl/rate_of_change_checker_core.sv
// Rate-of-change checker for one series of timestamped samples.
// Input channel: a request carries series_start, sample_value (hundredths),
// sample_time (seconds) and sample_usable; it is taken when i_in_valid is
// high and o_in_stall is low. One result request follows each input on the
// output channel, taken when o_out_valid is high and i_out_stall is low.
// Configuration: the five configuration registers are written through i_cfg_valid,
// i_cfg_index and i_cfg_data. The user is to write them only while the
// block is idle; the block itself does not enforce it. o_cfg_ready stays high.
// Datapath: a sample that yields a rate runs a scale by 3600 and a bit-serial
// divide that retires one quotient bit per cycle over VALUE_BITS + 12 bits.
// The next sample can be taken once its result is loaded into the output
// register. A sample that yields no rate skips the scale and the divide.
// One sample is processed at a time; o_in_stall is high while it is at work.
// Reset clears the configuration registers, the predecessor and the series flag.
// When the receiver stalls, the result is held in the output register; the
// next sample is still taken and finishes up to the output, where it waits.
module rate_of_change_checker_core #(
    parameter int VALUE_BITS = rocc_pkg::VALUE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [rocc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [rocc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // Sample input
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_series_start,
    input  logic signed [VALUE_BITS-1:0]        i_sample_value,
    input  logic [rocc_pkg::TIME_W-1:0]         i_sample_time,
    input  logic                                i_sample_usable,
    // Result output
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [rocc_pkg::STATUS_W-1:0]       o_check_status,
    output logic signed [rocc_pkg::RATE_W-1:0]  o_rate_per_hour,
    output logic                                o_rate_valid,
    output logic                                o_series_flagged
);

    localparam int DIFF_W = VALUE_BITS + 1;
    localparam int DT_W   = rocc_pkg::TIME_W + 1;
    localparam int NUM_W  = VALUE_BITS + rocc_pkg::SCALE_W;
    localparam int CW     = (NUM_W > rocc_pkg::RATE_W) ? NUM_W : rocc_pkg::RATE_W;

    rocc_pkg::t_cfg   w_cfg;
    rocc_pkg::t_state r_state;
    rocc_pkg::t_state n_state;

    // Sample under work
    logic [VALUE_BITS-1:0]          r_val;
    logic [rocc_pkg::TIME_W-1:0]    r_tim;
    logic                           r_use;

    // Predecessor and series state
    logic [VALUE_BITS-1:0]          r_last_value;
    logic [rocc_pkg::TIME_W-1:0]    r_last_time;
    logic                           r_last_present;
    logic                           r_failure;

    // Datapath
    logic [DIFF_W-1:0]              r_diff;
    logic [DT_W-1:0]                r_dt;
    logic [NUM_W-1:0]               r_num;
    logic [rocc_pkg::TIME_W-1:0]    r_den;
    logic                           r_rate_neg;
    logic [rocc_pkg::RATE_W-1:0]    r_mag;
    rocc_pkg::t_status              r_status;
    logic [rocc_pkg::RATE_W-1:0]    r_rate;
    logic                           r_rvalid;

    // Output register
    logic                           r_out_valid;
    rocc_pkg::t_status              r_out_status;
    logic [rocc_pkg::RATE_W-1:0]    r_out_rate;
    logic                           r_out_rvalid;
    logic                           r_out_flag;

    logic                           w_accept;
    logic                           w_commit;
    logic                           w_rated;
    logic                           w_conflict;
    logic [DIFF_W-1:0]              w_diff_abs;
    logic [DT_W-1:0]                w_dt_abs;
    logic [NUM_W-1:0]               w_x15;
    logic                           w_div_start;
    logic                           w_div_busy;
    logic [NUM_W-1:0]               w_quot;
    logic [rocc_pkg::RATE_W-1:0]    w_sat_lim;
    logic [CW-1:0]                  w_q_ext;
    logic                           w_ge_qc;
    logic                           w_ge_alarm;
    logic                           w_ge_alert;
    logic                           w_mag_hi;
    logic                           w_fail;
    rocc_pkg::t_status              w_class;

    rocc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_ready (o_cfg_ready),
        .o_cfg   (w_cfg)
    );

    rocc_div #(
        .NUM_W (NUM_W),
        .DEN_W (rocc_pkg::TIME_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_busy  (w_div_busy),
        .o_quot  (w_quot)
    );

    // Handshakes
    assign o_in_stall = (r_state != rocc_pkg::S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_commit   = (r_state == rocc_pkg::S_DONE) && (!r_out_valid || !i_out_stall);

    // Decide the path of the sample against its predecessor
    assign w_rated    = r_use && r_last_present && (r_tim != r_last_time);
    assign w_conflict = r_use && r_last_present && (r_tim == r_last_time) &&
                        (r_val != r_last_value);

    // Magnitudes of the value and time differences
    assign w_diff_abs = r_diff[DIFF_W-1] ? (~r_diff + 1'b1) : r_diff;
    assign w_dt_abs   = r_dt[DT_W-1] ? (~r_dt + 1'b1) : r_dt;

    // One x15 step of the scale by 3600
    assign w_x15 = (r_num << rocc_pkg::MUL_DIGIT) - r_num;

    // Saturate the quotient magnitude to the 48-bit range of the sign
    assign w_sat_lim = r_rate_neg ? rocc_pkg::RATE_MAG_NEG : rocc_pkg::RATE_MAG_POS;
    assign w_q_ext   = CW'(w_quot);

    // Compare the rate magnitude against the limits
    assign w_mag_hi   = |r_mag[rocc_pkg::RATE_W-1:rocc_pkg::LIMIT_W];
    assign w_ge_qc    = w_mag_hi || (r_mag[rocc_pkg::LIMIT_W-1:0] >= w_cfg.qc_limit);
    assign w_ge_alarm = w_mag_hi || (r_mag[rocc_pkg::LIMIT_W-1:0] >= w_cfg.alarm_limit);
    assign w_ge_alert = w_mag_hi || (r_mag[rocc_pkg::LIMIT_W-1:0] >= w_cfg.alert_limit);

    always_comb begin
        if ((w_cfg.enables[rocc_pkg::EN_QC] && w_ge_qc) ||
            (w_cfg.accum && r_diff[DIFF_W-1])) begin
            w_class = rocc_pkg::ST_QC;
        end else if (w_cfg.enables[rocc_pkg::EN_ALARM] && w_ge_alarm) begin
            w_class = rocc_pkg::ST_ALARM;
        end else if (w_cfg.enables[rocc_pkg::EN_ALERT] && w_ge_alert) begin
            w_class = rocc_pkg::ST_ALERT;
        end else begin
            w_class = rocc_pkg::ST_OKAY;
        end
    end

    assign w_fail = (r_status != rocc_pkg::ST_NONE) && (r_status != rocc_pkg::ST_OKAY);

    // Sequence one sample through its steps
    always_comb begin
        n_state     = r_state;
        w_div_start = 1'b0;
        unique case (r_state)
            rocc_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = rocc_pkg::S_PREP;
                end
            end
            rocc_pkg::S_PREP: begin
                n_state = w_rated ? rocc_pkg::S_ABS : rocc_pkg::S_DONE;
            end
            rocc_pkg::S_ABS: begin
                n_state = rocc_pkg::S_MUL1;
            end
            rocc_pkg::S_MUL1: begin
                n_state = rocc_pkg::S_MUL2;
            end
            rocc_pkg::S_MUL2: begin
                n_state = rocc_pkg::S_DSTART;
            end
            rocc_pkg::S_DSTART: begin
                w_div_start = 1'b1;
                n_state     = rocc_pkg::S_DIV;
            end
            rocc_pkg::S_DIV: begin
                if (!w_div_busy) begin
                    n_state = rocc_pkg::S_SAT;
                end
            end
            rocc_pkg::S_SAT: begin
                n_state = rocc_pkg::S_CLASS;
            end
            rocc_pkg::S_CLASS: begin
                n_state = rocc_pkg::S_DONE;
            end
            rocc_pkg::S_DONE: begin
                if (w_commit) begin
                    n_state = rocc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rocc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rocc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Update the predecessor flag, series flag and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_present <= 1'b0;
            r_failure      <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (w_accept && i_series_start) begin
                r_last_present <= 1'b0;
                r_failure      <= 1'b0;
            end
            if (w_commit) begin
                r_failure   <= r_failure || w_fail;
                r_out_valid <= 1'b1;
                if (r_use && (r_status != rocc_pkg::ST_QC)) begin
                    r_last_present <= 1'b1;
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        // Capture the request
        if (w_accept) begin
            r_val <= i_sample_value;
            r_tim <= i_sample_time;
            r_use <= i_sample_usable;
        end
        unique case (r_state)
            rocc_pkg::S_PREP: begin
                r_diff   <= {r_val[VALUE_BITS-1], r_val} -
                            {r_last_value[VALUE_BITS-1], r_last_value};
                r_dt     <= {1'b0, r_tim} - {1'b0, r_last_time};
                r_status <= w_conflict ? rocc_pkg::ST_CONFLICT : rocc_pkg::ST_NONE;
                r_rate   <= '0;
                r_rvalid <= 1'b0;
            end
            rocc_pkg::S_ABS: begin
                r_num      <= NUM_W'(w_diff_abs[VALUE_BITS-1:0]);
                r_den      <= w_dt_abs[rocc_pkg::TIME_W-1:0];
                r_rate_neg <= r_diff[DIFF_W-1] ^ r_dt[DT_W-1];
            end
            rocc_pkg::S_MUL1: begin
                r_num <= w_x15;
            end
            rocc_pkg::S_MUL2: begin
                r_num <= w_x15 << rocc_pkg::MUL_DIGIT;
            end
            rocc_pkg::S_SAT: begin
                if (w_q_ext > CW'(w_sat_lim)) begin
                    r_mag <= w_sat_lim;
                end else begin
                    r_mag <= w_q_ext[rocc_pkg::RATE_W-1:0];
                end
            end
            rocc_pkg::S_CLASS: begin
                r_status <= w_class;
                r_rate   <= r_rate_neg ? (~r_mag + 1'b1) : r_mag;
                r_rvalid <= 1'b1;
            end
            default: begin
            end
        endcase
        // Load the result and advance the predecessor
        if (w_commit) begin
            r_out_status <= r_status;
            r_out_rate   <= r_rate;
            r_out_rvalid <= r_rvalid;
            r_out_flag   <= r_failure || w_fail;
            if (r_use && (r_status != rocc_pkg::ST_QC)) begin
                r_last_value <= r_val;
                r_last_time  <= r_tim;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_check_status   = r_out_status;
    assign o_rate_per_hour  = r_out_rate;
    assign o_rate_valid     = r_out_rvalid;
    assign o_series_flagged = r_out_flag;

    // The divider runs only while the sequencer waits on it
    a_div_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_busy |-> (r_state == rocc_pkg::S_DIV))
        else $error("divider busy outside the divide step");

    // A rated result always carries a rate classification
    a_rate_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_rate_valid) |->
        ((o_check_status == rocc_pkg::ST_OKAY) || (o_check_status == rocc_pkg::ST_QC) ||
         (o_check_status == rocc_pkg::ST_ALARM) || (o_check_status == rocc_pkg::ST_ALERT)))
        else $error("rated result without a rate status");

    // An unrated result carries a zero rate
    a_rate_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_rate_valid) |-> (o_rate_per_hour == '0))
        else $error("rate present on an unrated result");

    // Any failure status shows in the series flag
    a_flag_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_check_status != rocc_pkg::ST_NONE) &&
         (o_check_status != rocc_pkg::ST_OKAY)) |-> o_series_flagged)
        else $error("failure status without series flag");

    // A finished sample reaches the output once the receiver moves
    a_done_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == rocc_pkg::S_DONE) && !i_out_stall) |=> o_out_valid)
        else $error("finished sample not presented");

endmodule

>>> hdl/rocc_cfg.sv
module rocc_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic [rocc_pkg::CFG_IDX_W-1:0]  i_index,
    input  logic [rocc_pkg::CFG_DATA_W-1:0] i_data,
    output logic                            o_ready,
    output rocc_pkg::t_cfg                  o_cfg
);

    rocc_pkg::t_cfg r_cfg;

    // Always take a write request
    assign o_ready = 1'b1;
    assign o_cfg   = r_cfg;

    // Decode the register index and write the addressed field
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_valid) begin
            unique case (i_index)
                rocc_pkg::CFG_QC_LIMIT: begin
                    r_cfg.qc_limit <= i_data[rocc_pkg::LIMIT_W-1:0];
                end
                rocc_pkg::CFG_ALARM_LIMIT: begin
                    r_cfg.alarm_limit <= i_data[rocc_pkg::LIMIT_W-1:0];
                end
                rocc_pkg::CFG_ALERT_LIMIT: begin
                    r_cfg.alert_limit <= i_data[rocc_pkg::LIMIT_W-1:0];
                end
                rocc_pkg::CFG_ENABLES: begin
                    r_cfg.enables <= i_data[rocc_pkg::EN_W-1:0];
                end
                rocc_pkg::CFG_ACCUM: begin
                    r_cfg.accum <= i_data[0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

>>> hdl/rocc_div.sv
module rocc_div #(
    parameter int NUM_W = rocc_pkg::VALUE_BITS_DEF + rocc_pkg::SCALE_W,
    parameter int DEN_W = rocc_pkg::TIME_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_busy,
    output logic [NUM_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_q;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;

    logic [DEN_W:0]   w_shift;
    logic [DEN_W:0]   w_trial;
    logic             w_ge;

    // Bring down the next numerator bit and try one subtract
    assign w_shift = {r_rem, r_q[NUM_W-1]};
    assign w_ge    = (w_shift >= {1'b0, r_den});
    assign w_trial = w_shift - {1'b0, r_den};

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_q;

    // Count the remaining quotient bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(NUM_W);
        end else if (o_busy) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // Shift the numerator out and the quotient in, one bit a cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (o_busy) begin
            r_q   <= {r_q[NUM_W-2:0], w_ge};
            r_rem <= w_ge ? w_trial[DEN_W-1:0] : w_shift[DEN_W-1:0];
        end
    end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int VB            = rocc_pkg::VALUE_BITS_DEF;
    localparam int MAX_IDLE      = 17;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 80;
    localparam int PHASE_ITEMS   = 140;
    localparam logic [rocc_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;
    localparam longint RATE_TOP    = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint RATE_BOTTOM = -RATE_TOP - 1;

    // One expected result request
    typedef struct packed {
        logic [rocc_pkg::STATUS_W-1:0]      status;
        logic signed [rocc_pkg::RATE_W-1:0] rate;
        logic                               rate_valid;
        logic                               flagged;
    } t_sample_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                                i_cfg_valid = 1'b0;
    logic                                o_cfg_ready;
    logic [rocc_pkg::CFG_IDX_W-1:0]      i_cfg_index = '0;
    logic [rocc_pkg::CFG_DATA_W-1:0]     i_cfg_data = '0;

    logic                                i_in_valid = 1'b0;
    logic                                o_in_stall;
    logic                                i_series_start = 1'b0;
    logic signed [VB-1:0]                i_sample_value = '0;
    logic [rocc_pkg::TIME_W-1:0]         i_sample_time = '0;
    logic                                i_sample_usable = 1'b0;

    logic                                o_out_valid;
    logic                                i_out_stall = 1'b0;
    logic [rocc_pkg::STATUS_W-1:0]       o_check_status;
    logic signed [rocc_pkg::RATE_W-1:0]  o_rate_per_hour;
    logic                                o_rate_valid;
    logic                                o_series_flagged;

    // Shadow registers and series state of the checker
    logic [rocc_pkg::LIMIT_W-1:0] lim_qc = '0;
    logic [rocc_pkg::LIMIT_W-1:0] lim_alarm = '0;
    logic [rocc_pkg::LIMIT_W-1:0] lim_alert = '0;
    logic [rocc_pkg::EN_W-1:0]    lim_en = '0;
    logic                         accum_on = 1'b0;
    logic signed [VB-1:0]         prior_value = '0;
    logic [rocc_pkg::TIME_W-1:0]  prev_stamp = '0;
    logic                         prev_present = 1'b0;
    logic                         series_fail = 1'b0;

    t_sample_result awaited_results[$];
    t_sample_result exp_r;
    int             mismatch_count = 0;
    int             rx_wait = 0;
    int             hold_left = 0;
    logic           hold_go = 1'b0;
    logic           rx_idle_on = 1'b0;
    bit             tx_idle_on = 1'b0;

    rate_of_change_checker_core uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_series_start   (i_series_start),
        .i_sample_value   (i_sample_value),
        .i_sample_time    (i_sample_time),
        .i_sample_usable  (i_sample_usable),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_check_status   (o_check_status),
        .o_rate_per_hour  (o_rate_per_hour),
        .o_rate_valid     (o_rate_valid),
        .o_series_flagged (o_series_flagged)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Compute the result of one sample and advance the series state
    function automatic t_sample_result predict_rate_check(input logic start,
                                                          input logic signed [VB-1:0] value,
                                                          input logic [31:0] stamp,
                                                          input logic usable);
        t_sample_result r;
        longint v_new;
        longint v_old;
        longint t_new;
        longint t_old;
        longint diff;
        longint dt;
        longint rate;
        longint mag;
        logic   keep_prev;
        r = '0;
        r.status = rocc_pkg::ST_NONE;
        keep_prev = 1'b0;
        rate = 0;
        if (start) begin
            prev_present = 1'b0;
            series_fail = 1'b0;
        end
        if (usable && prev_present) begin
            v_new = value;
            v_old = prior_value;
            t_new = stamp;
            t_old = prev_stamp;
            diff = v_new - v_old;
            dt = t_new - t_old;
            if (dt == 0) begin
                // Same time stamp: a different value is a conflict
                if (diff != 0) begin
                    r.status = rocc_pkg::ST_CONFLICT;
                    series_fail = 1'b1;
                end
            end else begin
                rate = (diff * 3600) / dt;
                if (rate > RATE_TOP) rate = RATE_TOP;
                if (rate < RATE_BOTTOM) rate = RATE_BOTTOM;
                r.rate_valid = 1'b1;
                r.rate = rate[rocc_pkg::RATE_W-1:0];
                mag = (rate < 0) ? -rate : rate;
                if ((lim_en[rocc_pkg::EN_QC] && mag >= lim_qc) || (accum_on && diff < 0)) begin
                    r.status = rocc_pkg::ST_QC;
                    keep_prev = 1'b1;
                end else if (lim_en[rocc_pkg::EN_ALARM] && mag >= lim_alarm) begin
                    r.status = rocc_pkg::ST_ALARM;
                end else if (lim_en[rocc_pkg::EN_ALERT] && mag >= lim_alert) begin
                    r.status = rocc_pkg::ST_ALERT;
                end else begin
                    r.status = rocc_pkg::ST_OKAY;
                end
                if (r.status != rocc_pkg::ST_OKAY) series_fail = 1'b1;
            end
        end
        // A QC-failed sample leaves the predecessor in place
        if (usable && !keep_prev) begin
            prior_value = value;
            prev_stamp = stamp;
            prev_present = 1'b1;
        end
        r.flagged = series_fail;
        return r;
    endfunction

    // Offer one sample request and record its expected result on acceptance
    task automatic send_sample(input logic start, input logic [31:0] value,
                               input logic [31:0] stamp, input logic usable);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_series_start  <= start;
        i_sample_value  <= value[VB-1:0];
        i_sample_time   <= stamp;
        i_sample_usable <= usable;
        do @(posedge i_clk); while (o_in_stall);
        awaited_results.push_back(predict_rate_check(start, value[VB-1:0], stamp, usable));
    endtask

    // Stop offering and wait until every result has come back
    task automatic settle_block();
        i_in_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write one register and mirror it in the shadow copy
    task automatic write_reg(input logic [rocc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            rocc_pkg::CFG_QC_LIMIT:    lim_qc    = data[rocc_pkg::LIMIT_W-1:0];
            rocc_pkg::CFG_ALARM_LIMIT: lim_alarm = data[rocc_pkg::LIMIT_W-1:0];
            rocc_pkg::CFG_ALERT_LIMIT: lim_alert = data[rocc_pkg::LIMIT_W-1:0];
            rocc_pkg::CFG_ENABLES:     lim_en    = data[rocc_pkg::EN_W-1:0];
            rocc_pkg::CFG_ACCUM:       accum_on  = data[0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_all_regs(input logic [31:0] qc, input logic [31:0] alarm,
                                  input logic [31:0] alert, input logic [31:0] en,
                                  input logic [31:0] accum);
        write_reg(rocc_pkg::CFG_QC_LIMIT, qc);
        write_reg(rocc_pkg::CFG_ALARM_LIMIT, alarm);
        write_reg(rocc_pkg::CFG_ALERT_LIMIT, alert);
        write_reg(rocc_pkg::CFG_ENABLES, en);
        write_reg(rocc_pkg::CFG_ACCUM, accum);
    endtask

    // Receiver: check each result, then draw the stall before the next one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            rx_wait = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (awaited_results.size() == 0) begin
                    $error("result request with no expected result waiting");
                    mismatch_count++;
                end else begin
                    exp_r = awaited_results.pop_front();
                    if (o_check_status !== exp_r.status) begin
                        $error("check_status: expected %0d, actual %0d",
                               exp_r.status, o_check_status);
                        mismatch_count++;
                    end
                    if (o_rate_per_hour !== exp_r.rate) begin
                        $error("rate_per_hour: expected %0d, actual %0d",
                               exp_r.rate, o_rate_per_hour);
                        mismatch_count++;
                    end
                    if (o_rate_valid !== exp_r.rate_valid) begin
                        $error("rate_valid: expected %0d, actual %0d",
                               exp_r.rate_valid, o_rate_valid);
                        mismatch_count++;
                    end
                    if (o_series_flagged !== exp_r.flagged) begin
                        $error("series_flagged: expected %0d, actual %0d",
                               exp_r.flagged, o_series_flagged);
                        mismatch_count++;
                    end
                end
                rx_wait = rx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
            end else if (rx_wait > 0) begin
                rx_wait = rx_wait - 1;
            end
            i_out_stall <= (rx_wait > 0) || (hold_left > 0);
        end
    end

    // Long receiver hold-off, counted on its own
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_go) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Registers at reset: no limits, so any rate is okay
    task automatic test_reset_state();
        send_sample(1'b0, 32'd100, 32'd1000, 1'b1);
        send_sample(1'b0, 32'd200, 32'd1060, 1'b1);
        send_sample(1'b0, 32'd50, 32'd2000, 1'b0);
        settle_block();
    endtask

    // Each status, conflict, kept predecessor, backward time, extremes
    task automatic test_classification();
        write_all_regs(32'd100000, 32'd50000, 32'd10000, 32'd7, 32'd0);
        send_sample(1'b1, 32'd0, 32'd0, 1'b1);
        send_sample(1'b0, 32'd1, 32'd3600, 1'b1);
        send_sample(1'b0, 32'd1, 32'd3600, 1'b1);
        send_sample(1'b0, 32'd5, 32'd3600, 1'b1);
        send_sample(1'b0, 32'd105, 32'd3620, 1'b1);
        send_sample(1'b0, 32'd405, 32'd3640, 1'b1);
        send_sample(1'b0, 32'd1405, 32'd3660, 1'b1);
        send_sample(1'b0, 32'd406, 32'd3700, 1'b1);
        send_sample(1'b0, 32'd500, 32'd3600, 1'b1);
        send_sample(1'b1, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1);
        send_sample(1'b0, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1);
        send_sample(1'b0, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1);
        send_sample(1'b1, 32'h8000_0000, 32'hFFFF_FFFE, 1'b1);
        send_sample(1'b0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        settle_block();
    endtask

    // Accumulating mode: a fall fails even when the rate truncates to zero
    task automatic test_accumulating();
        write_all_regs(32'd0, 32'd0, 32'd0, 32'd0, 32'd1);
        send_sample(1'b1, 32'd1000, 32'd100, 1'b1);
        send_sample(1'b0, 32'd999, 32'd100000, 1'b1);
        send_sample(1'b0, 32'd1000, 32'd100001, 1'b1);
        send_sample(1'b0, 32'd2000, 32'd100002, 1'b1);
        settle_block();
        // An index outside the register map changes nothing
        write_reg(CFG_IDX_UNUSED, 32'hFFFF_FFFF);
        send_sample(1'b0, 32'd1500, 32'd100010, 1'b1);
        settle_block();
    endtask

    // Hold the receiver off while the sender keeps offering, then pause the sender
    task automatic test_output_hold();
        write_all_regs(32'd2000000, 32'd500000, 32'd100000, 32'd7, 32'd0);
        tx_idle_on = 1'b0;
        hold_go <= 1'b1;
        @(posedge i_clk);
        hold_go <= 1'b0;
        send_sample(1'b1, 32'd0, 32'd0, 1'b1);
        for (int k = 1; k < 10; k++) begin
            send_sample(1'b0, $urandom_range(0, 4000) - 2000, k * 30, 1'b1);
        end
        settle_block();
    endtask

    // Random series under several register settings
    task automatic test_random_settings();
        logic [31:0] t_cur;
        logic [31:0] v_cur;
        int          kind;
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: write_all_regs(32'd0, 32'd0, 32'd0, 32'd7, 32'd0);
                1: write_all_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                  32'hFFFF_FFFF, 32'hFFFF_FFFF);
                2: write_all_regs($urandom, $urandom, $urandom, $urandom, $urandom);
                default: write_all_regs($urandom_range(200000, 4000000),
                                        $urandom_range(50000, 1000000),
                                        $urandom_range(0, 300000),
                                        $urandom_range(0, 7), $urandom_range(0, 1));
            endcase
            tx_idle_on = (ph % 3) != 1;
            rx_idle_on <= (ph % 3) != 2;
            t_cur = $urandom;
            v_cur = $urandom;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                kind = $urandom_range(0, 99);
                if (kind < 6) begin
                    // Fresh series anywhere in range
                    t_cur = $urandom;
                    v_cur = $urandom;
                    send_sample(1'b1, v_cur, t_cur, 1'b1);
                end else if (kind < 80) begin
                    // Well-formed step near the limits
                    kind = $urandom_range(0, 19);
                    if (kind < 14) t_cur = t_cur + $urandom_range(1, 3600);
                    else if (kind < 17) t_cur = t_cur + $urandom_range(3601, 1000000);
                    else t_cur = t_cur - $urandom_range(1, 600);
                    if ($urandom_range(0, 9) == 0) v_cur = v_cur + $urandom;
                    else v_cur = v_cur + $urandom_range(0, 6000) - 3000;
                    send_sample(1'b0, v_cur, t_cur, $urandom_range(0, 15) != 0);
                end else if (kind < 88) begin
                    // Repeat the time stamp, same or different value
                    if ($urandom_range(0, 1)) v_cur = v_cur + $urandom_range(1, 50);
                    send_sample(1'b0, v_cur, t_cur, 1'b1);
                end else begin
                    // Noise
                    send_sample($urandom_range(0, 1), $urandom, $urandom,
                                $urandom_range(0, 1));
                end
            end
            settle_block();
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        tx_idle_on = 1'b1;
        rx_idle_on <= 1'b1;
        test_reset_state();
        test_classification();
        test_accumulating();
        test_output_hold();
        test_random_settings();
        settle_block();
        if (mismatch_count == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    // Run limit
    initial begin
        #(6_000_000);
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
